### hdl/vctc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// vctc_pkg: shared types and constants of the value change trace capture
// Sizes of the ring and event tables, mode and command codes, sequencer
// states and the write-back control word of the event table.
// -----------------------------------------------------------------------------
package vctc_pkg;

   // storage sizes
   localparam int RING_DEPTH  = 1024;
   localparam int EVENT_COUNT = 128;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int FILL_W      = $clog2(RING_DEPTH + 1);
   localparam int EV_W        = 7;
   localparam int CHAN_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(RING_DEPTH);
   localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

   // item modes
   localparam logic [1:0] MODE_LOG       = 2'd0;
   localparam logic [1:0] MODE_CMD       = 2'd1;
   localparam logic [1:0] MODE_READ_RING = 2'd2;
   localparam logic [1:0] MODE_READ_INIT = 2'd3;

   // capture commands, also the capture mode encoding
   localparam logic [1:0] CMD_STOP    = 2'd0;
   localparam logic [1:0] CMD_AUTO    = 2'd1;
   localparam logic [1:0] CMD_TRIGGER = 2'd2;
   localparam logic [1:0] CMD_SINGLE  = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } seq_state_type;

   // one ring entry
   typedef struct packed {
      logic [DATA_W-1:0] time_stamp;
      logic [EV_W-1:0]   event_num;
      logic [DATA_W-1:0] value;
   } ring_entry_type;

   // write-back controls for the event table
   typedef struct packed {
      logic              clear;
      logic              store;
      logic [EV_W-1:0]   store_event;
      logic [DATA_W-1:0] store_value;
      logic              init_write;
      logic [EV_W-1:0]   init_event;
      logic [DATA_W-1:0] init_value;
   } evt_ctl_type;

endpackage

### hdl/vctc_event_table.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// vctc_event_table: per-event history of the trace capture
// Seen flags in flops (cleared at once on restart), last value and initial
// value memories with one registered read port and one write port each.
// -----------------------------------------------------------------------------
module vctc_event_table
   import vctc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // registered read of both memories
   input  logic              rd_en,
   input  logic [EV_W-1:0]   rd_event,
   output logic [DATA_W-1:0] prev_value,
   output logic [DATA_W-1:0] init_value,
   // seen flag lookups
   input  logic [EV_W-1:0]   query_a,
   input  logic [EV_W-1:0]   query_b,
   output logic              seen_a,
   output logic              seen_b,
   // write-back
   input  evt_ctl_type       ctl
);

   logic [EVENT_COUNT-1:0] seen_ff;
   logic [DATA_W-1:0]      prev_mem [EVENT_COUNT];
   logic [DATA_W-1:0]      init_mem [EVENT_COUNT];
   logic [DATA_W-1:0]      prev_rd_ff;
   logic [DATA_W-1:0]      init_rd_ff;

   // seen flags: restart clears all, a stored word sets its event
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         seen_ff <= '0;
      end else if (ctl.store) begin
         seen_ff[ctl.store_event] <= 1'b1;
      end
   end

   // last value memory
   always_ff @(posedge clock) begin
      if (ctl.store) begin
         prev_mem[ctl.store_event] <= ctl.store_value;
      end
      if (rd_en) begin
         prev_rd_ff <= prev_mem[rd_event];
      end
   end

   // initial value memory
   always_ff @(posedge clock) begin
      if (ctl.init_write) begin
         init_mem[ctl.init_event] <= ctl.init_value;
      end
      if (rd_en) begin
         init_rd_ff <= init_mem[rd_event];
      end
   end

   assign prev_value = prev_rd_ff;
   assign init_value = init_rd_ff;
   assign seen_a     = seen_ff[query_a];
   assign seen_b     = seen_ff[query_b];

endmodule

### hdl/value_change_trace_capture_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// value_change_trace_capture_top: debug trace capture into a ring buffer
// Logs records of the selected channel on value change or pulse events,
// with stop, auto, trigger and single capture modes and read-back.
//
//   channel   ports                 direction  content
//   req       req_valid/req_ready   in         log, command or read word
//   rsp       rsp_valid/rsp_ready   out        stored flag, status, entry
//   csr       csr_valid/csr_ready   in         capture channel
//
// Each word is accepted in the idle state, which reads the ring entry at the
// write pointer (or read index) and the event memories; the execute state
// then modifies and writes back and loads the result register.
// The next word is accepted while the result waits; a word held in the
// execute state waits there only while the result register is still full.
// Synchronous active-high reset: single mode, running, empty ring.
// -----------------------------------------------------------------------------
module value_change_trace_capture_top
   import vctc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CHAN_W-1:0]    csr_wdata,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [CHAN_W-1:0]    req_channel,
   input  logic [EV_W-1:0]      req_event_id,
   input  logic [DATA_W-1:0]    req_sample_value,
   input  logic [DATA_W-1:0]    req_timestamp,
   input  logic                 req_is_pulse_event,
   input  logic [1:0]           req_command,
   input  logic [RING_AW-1:0]   req_read_index,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_stored,
   output logic [1:0]           rsp_capture_mode,
   output logic                 rsp_running,
   output logic [FILL_W-1:0]    rsp_fill_count,
   output logic [RING_AW-1:0]   rsp_write_position,
   output logic                 rsp_wrapped,
   output logic [DATA_W-1:0]    rsp_entry_timestamp,
   output logic [EV_W-1:0]      rsp_entry_event,
   output logic [DATA_W-1:0]    rsp_entry_value,
   output logic                 rsp_entry_seen
);

   // sequencer
   seq_state_type state_ff, state_in;
   logic          req_fire;
   logic          go;

   // held word
   logic [1:0]          item_mode_ff;
   logic [CHAN_W-1:0]   item_chan_ff;
   logic [EV_W-1:0]     item_event_ff;
   logic [DATA_W-1:0]   item_value_ff;
   logic [DATA_W-1:0]   item_time_ff;
   logic                item_pulse_ff;
   logic [1:0]          item_cmd_ff;

   // capture state
   logic [CHAN_W-1:0]   channel_ff;
   logic [RING_AW-1:0]  write_ptr_ff, write_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   stop_ptr_ff, stop_ptr_in;
   logic                run_ff, run_in;
   logic                armed_ff, armed_in;
   logic [EV_W-1:0]     trig_event_ff, trig_event_in;
   logic [1:0]          mode_ff, mode_in;
   logic                wrap_ff, wrap_in;

   // ring memory
   ring_entry_type      ring_mem [RING_DEPTH];
   ring_entry_type      ring_rd_ff;
   logic [RING_AW-1:0]  ring_rd_addr;
   logic                ring_we;

   // event table
   evt_ctl_type         evt_ctl;
   logic [DATA_W-1:0]   evt_prev;
   logic [DATA_W-1:0]   evt_init;
   logic                seen_item;
   logic                seen_ring;

   // execute-stage terms
   logic                trig_hit;
   logic [FILL_W-1:0]   stop_eff;
   logic                keep;
   logic                overwrite;
   logic [RING_AW-1:0]  wp_next;

   // result register
   logic                rsp_valid_ff;
   logic                stored_ff, stored_in;
   logic [DATA_W-1:0]   e_time_ff, e_time_in;
   logic [EV_W-1:0]     e_event_ff, e_event_in;
   logic [DATA_W-1:0]   e_value_ff, e_value_in;
   logic                e_seen_ff, e_seen_in;

   // ---------------------------------------------------------------------
   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      go        = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: go = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            go        = 1'b0;
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_mode_ff  <= req_mode;
         item_chan_ff  <= req_channel;
         item_event_ff <= req_event_id;
         item_value_ff <= req_sample_value;
         item_time_ff  <= req_timestamp;
         item_pulse_ff <= req_is_pulse_event;
         item_cmd_ff   <= req_command;
      end
   end

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= '0;
      end else if (csr_valid) begin
         channel_ff <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------------
   // ring memory: read on accept, write back in the execute cycle
   assign ring_rd_addr = (req_mode == MODE_READ_RING) ? req_read_index : write_ptr_ff;
   assign ring_we      = go && keep;

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[write_ptr_ff] <= '{time_stamp: item_time_ff,
                                     event_num:  item_event_ff,
                                     value:      item_value_ff};
      end
      if (req_fire) begin
         ring_rd_ff <= ring_mem[ring_rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // execute: trigger match, change filter, overwrite detection
   always_comb begin
      trig_hit  = (item_mode_ff == MODE_LOG) && run_ff && armed_ff &&
                  (item_event_ff == trig_event_ff);
      stop_eff  = trig_hit ? {1'b0, write_ptr_ff} : stop_ptr_ff;
      keep      = (item_mode_ff == MODE_LOG) && (item_chan_ff == channel_ff) && run_ff &&
                  !(seen_item && (evt_prev == item_value_ff) && !item_pulse_ff);
      overwrite = keep && (fill_ff == FILL_FULL) && ({1'b0, write_ptr_ff} != stop_eff);
      wp_next   = (write_ptr_ff == RING_LAST) ? '0 : write_ptr_ff + 1'b1;
   end

   // event table write-back
   always_comb begin
      evt_ctl             = '0;
      evt_ctl.clear       = go && (item_mode_ff == MODE_CMD) && (item_cmd_ff != CMD_STOP);
      evt_ctl.store       = go && keep;
      evt_ctl.store_event = item_event_ff;
      evt_ctl.store_value = item_value_ff;
      evt_ctl.init_write  = go && overwrite && seen_ring;
      evt_ctl.init_event  = ring_rd_ff.event_num;
      evt_ctl.init_value  = ring_rd_ff.value;
   end

   vctc_event_table u_event_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_fire),
      .rd_event   (req_event_id),
      .prev_value (evt_prev),
      .init_value (evt_init),
      .query_a    (item_event_ff),
      .query_b    (ring_rd_ff.event_num),
      .seen_a     (seen_item),
      .seen_b     (seen_ring),
      .ctl        (evt_ctl)
   );

   // next capture state
   always_comb begin
      write_ptr_in  = write_ptr_ff;
      fill_in       = fill_ff;
      stop_ptr_in   = stop_eff;
      run_in        = run_ff;
      armed_in      = armed_ff && !trig_hit;
      trig_event_in = trig_event_ff;
      mode_in       = mode_ff;
      wrap_in       = wrap_ff || overwrite;
      case (item_mode_ff)
         MODE_LOG: begin
            if (keep) begin
               write_ptr_in = wp_next;
               if (fill_ff != FILL_FULL) begin
                  fill_in = fill_ff + 1'b1;
               end
               if ({1'b0, wp_next} == stop_eff) begin
                  run_in  = 1'b0;
                  mode_in = CMD_STOP;
               end
            end
         end
         MODE_CMD: begin
            case (item_cmd_ff)
               CMD_STOP: begin
                  run_in  = 1'b0;
                  mode_in = CMD_STOP;
               end
               CMD_AUTO, CMD_TRIGGER: begin
                  fill_in      = '0;
                  armed_in     = (item_cmd_ff == CMD_TRIGGER);
                  run_in       = 1'b1;
                  stop_ptr_in  = FILL_FULL;
                  mode_in      = item_cmd_ff;
                  wrap_in      = 1'b0;
                  write_ptr_in = '0;
                  if (item_cmd_ff == CMD_TRIGGER) begin
                     trig_event_in = item_event_ff;
                  end
               end
               default: begin
                  fill_in     = '0;
                  armed_in    = 1'b0;
                  run_in      = 1'b1;
                  stop_ptr_in = {1'b0, write_ptr_ff};
                  mode_in     = CMD_SINGLE;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff  <= '0;
         fill_ff       <= '0;
         stop_ptr_ff   <= '0;
         run_ff        <= 1'b1;
         armed_ff      <= 1'b0;
         trig_event_ff <= '0;
         mode_ff       <= CMD_SINGLE;
         wrap_ff       <= 1'b0;
      end else if (go) begin
         write_ptr_ff  <= write_ptr_in;
         fill_ff       <= fill_in;
         stop_ptr_ff   <= stop_ptr_in;
         run_ff        <= run_in;
         armed_ff      <= armed_in;
         trig_event_ff <= trig_event_in;
         mode_ff       <= mode_in;
         wrap_ff       <= wrap_in;
      end
   end

   // ---------------------------------------------------------------------
   // result fields
   always_comb begin
      stored_in  = keep;
      e_time_in  = '0;
      e_event_in = '0;
      e_value_in = '0;
      e_seen_in  = 1'b0;
      case (item_mode_ff)
         MODE_READ_RING: begin
            e_time_in  = ring_rd_ff.time_stamp;
            e_event_in = ring_rd_ff.event_num;
            e_value_in = ring_rd_ff.value;
            e_seen_in  = seen_ring;
         end
         MODE_READ_INIT: begin
            e_event_in = item_event_ff;
            e_value_in = evt_init;
            e_seen_in  = seen_item;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         stored_ff  <= stored_in;
         e_time_ff  <= e_time_in;
         e_event_ff <= e_event_in;
         e_value_ff <= e_value_in;
         e_seen_ff  <= e_seen_in;
      end
   end

   // status is taken after the update, so it reads the state registers
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stored          = stored_ff;
   assign rsp_capture_mode    = mode_ff;
   assign rsp_running         = run_ff;
   assign rsp_fill_count      = fill_ff;
   assign rsp_write_position  = write_ptr_ff;
   assign rsp_wrapped         = wrap_ff;
   assign rsp_entry_timestamp = e_time_ff;
   assign rsp_entry_event     = e_event_ff;
   assign rsp_entry_value     = e_value_ff;
   assign rsp_entry_seen      = e_seen_ff;

   // ---------------------------------------------------------------------
   // assertions
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count beyond ring depth");

   a_wrap_full: assert property (@(posedge clock) disable iff (reset)
      $rose(wrap_ff) |-> fill_ff == FILL_FULL)
      else $error("wrap flagged on a ring that is not full");

   a_init_full: assert property (@(posedge clock) disable iff (reset)
      evt_ctl.init_write |-> (fill_ff == FILL_FULL) && ring_we)
      else $error("initial value written without overwrite");

   a_armed_mode: assert property (@(posedge clock) disable iff (reset)
      armed_ff && run_ff |-> mode_ff == CMD_TRIGGER)
      else $error("trigger armed outside trigger mode");

   a_store_moves: assert property (@(posedge clock) disable iff (reset)
      ring_we |=> write_ptr_ff != $past(write_ptr_ff))
      else $error("write pointer did not advance on store");

endmodule
